[design/sfr_pkg.sv]
// Shared types, codes and reset values for the serial frame receiver.
// Used by sfr_in_stage, sfr_deframer, sfr_rsp_stage and the core top level.
package sfr_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;

   // Configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_SYNC_VALUE = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DATA_CODE  = 2'd1;

   // Configuration reset values
   localparam logic [ByteWidth-1:0] SYNC_VALUE_RESET = 8'd22;
   localparam logic [ByteWidth-1:0] DATA_CODE_RESET  = 8'd2;

   // Marker bytes seen while idle
   localparam logic [ByteWidth-1:0] MARK_FILE_START = 8'h7B;
   localparam logic [ByteWidth-1:0] MARK_FILE_END   = 8'h7D;

   // Control byte values
   localparam logic [ByteWidth-1:0] CTRL_EOT  = 8'd4;
   localparam logic [ByteWidth-1:0] CTRL_ENQ  = 8'd5;
   localparam logic [ByteWidth-1:0] CTRL_ACK  = 8'd6;
   localparam logic [ByteWidth-1:0] CTRL_NACK = 8'd21;

   localparam logic [ByteWidth-1:0] BYTE_ZERO = 8'h00;
   localparam logic [ByteWidth-1:0] BYTE_ONES = 8'hFF;
   localparam logic [ByteWidth-1:0] BYTE_ONE  = 8'h01;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_ADDR  = 3'd1,
      PH_CTRL  = 3'd2,
      PH_NUM   = 3'd3,
      PH_LEN   = 3'd4,
      PH_DATA  = 3'd5,
      PH_CHECK = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_PAYLOAD = 3'd0,
      EV_OK      = 3'd1,
      EV_BADCHK  = 3'd2,
      EV_CTRL    = 3'd3,
      EV_FSTART  = 3'd4,
      EV_FEND    = 3'd5
   } event_kind_type;

   typedef enum logic [2:0] {
      CLS_EOT     = 3'd0,
      CLS_ENQ     = 3'd1,
      CLS_ACK     = 3'd2,
      CLS_NACK    = 3'd3,
      CLS_UNKNOWN = 3'd4
   } ctrl_class_type;

   typedef struct packed {
      event_kind_type       event_kind;
      logic [ByteWidth-1:0] payload_value;
      logic [ByteWidth-1:0] frame_address;
      logic [ByteWidth-1:0] control_value;
      ctrl_class_type       control_class;
      logic [ByteWidth-1:0] frame_number;
      logic [ByteWidth-1:0] payload_length;
      logic                 is_last;
   } rsp_type;

   // Map a control byte to its class
   function automatic ctrl_class_type classify(input logic [ByteWidth-1:0] ctrl);
      ctrl_class_type cls;
      case (ctrl)
         CTRL_EOT:  cls = CLS_EOT;
         CTRL_ENQ:  cls = CLS_ENQ;
         CTRL_ACK:  cls = CLS_ACK;
         CTRL_NACK: cls = CLS_NACK;
         default:   cls = CLS_UNKNOWN;
      endcase
      return cls;
   endfunction

endpackage

[design/sfr_in_stage.sv]
// Input register for received bytes: one entry, refilled in the cycle it drains.
// Depends on sfr_pkg.
module sfr_in_stage
   import sfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ByteWidth-1:0] req_rx_byte,
   input  logic                 advance,
   output logic                 in_valid,
   output logic [ByteWidth-1:0] in_byte
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ByteWidth-1:0] byte_ff;
   logic                 accept;

   // Take a new request when empty or when the held byte moves on
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the byte until it is processed
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

[design/sfr_deframer.sv]
// Frame phase tracking, held header fields and running XOR check.
// Depends on sfr_pkg; produces at most one result per processed byte.
module sfr_deframer
   import sfr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [ByteWidth-1:0] in_byte,
   input  logic [ByteWidth-1:0] sync_value,
   input  logic [ByteWidth-1:0] data_code,
   output logic                 has_result,
   output rsp_type              result
);

   phase_type            phase_ff, phase_in;
   logic [ByteWidth-1:0] address_ff, address_in;
   logic [ByteWidth-1:0] control_ff, control_in;
   logic [ByteWidth-1:0] number_ff, number_in;
   logic [ByteWidth-1:0] length_ff, length_in;
   logic [ByteWidth-1:0] left_ff, left_in;
   logic [ByteWidth-1:0] xor_ff, xor_in;
   logic [ByteWidth-1:0] check_value;
   logic                 byte_is_zero;

   assign byte_is_zero = (in_byte == BYTE_ZERO);
   assign check_value  = (xor_ff == BYTE_ZERO || xor_ff == BYTE_ONES) ? BYTE_ONE : xor_ff;

   // Next state
   always_comb begin
      phase_in   = phase_ff;
      address_in = address_ff;
      control_in = control_ff;
      number_in  = number_ff;
      length_in  = length_ff;
      left_in    = left_ff;
      xor_in     = xor_ff;
      if (!(byte_is_zero && phase_ff != PH_DATA)) begin
         case (phase_ff)
            PH_IDLE: begin
               if (in_byte == sync_value) begin
                  phase_in = PH_ADDR;
               end
            end
            PH_ADDR: begin
               address_in = in_byte;
               phase_in   = PH_CTRL;
            end
            PH_CTRL: begin
               control_in = in_byte;
               phase_in   = PH_NUM;
            end
            PH_NUM: begin
               number_in = in_byte;
               phase_in  = (control_ff != data_code) ? PH_IDLE : PH_LEN;
            end
            PH_LEN: begin
               length_in = in_byte;
               left_in   = in_byte;
               xor_in    = BYTE_ZERO;
               phase_in  = PH_DATA;
            end
            PH_DATA: begin
               if (left_ff == BYTE_ZERO) begin
                  phase_in = PH_CHECK;
               end else begin
                  xor_in  = xor_ff ^ in_byte;
                  left_in = left_ff - BYTE_ONE;
                  if (left_ff == BYTE_ONE) begin
                     phase_in = PH_CHECK;
                  end
               end
            end
            PH_CHECK: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Result for the byte being processed
   always_comb begin
      has_result = 1'b0;
      result     = '0;
      if (!(byte_is_zero && phase_ff != PH_DATA)) begin
         case (phase_ff)
            PH_IDLE: begin
               if (in_byte != sync_value) begin
                  if (in_byte == MARK_FILE_START) begin
                     has_result        = 1'b1;
                     result.event_kind = EV_FSTART;
                  end else if (in_byte == MARK_FILE_END) begin
                     has_result        = 1'b1;
                     result.event_kind = EV_FEND;
                  end
               end
            end
            PH_NUM: begin
               if (control_ff != data_code) begin
                  has_result           = 1'b1;
                  result.event_kind    = EV_CTRL;
                  result.frame_address = address_ff;
                  result.control_value = control_ff;
                  result.control_class = classify(control_ff);
                  result.frame_number  = in_byte;
                  result.is_last       = 1'b1;
               end
            end
            PH_DATA: begin
               if (left_ff != BYTE_ZERO) begin
                  has_result            = 1'b1;
                  result.event_kind     = EV_PAYLOAD;
                  result.payload_value  = in_byte;
                  result.frame_address  = address_ff;
                  result.control_value  = control_ff;
                  result.frame_number   = number_ff;
                  result.payload_length = length_ff;
               end
            end
            PH_CHECK: begin
               has_result            = 1'b1;
               result.event_kind     = (in_byte == check_value) ? EV_OK : EV_BADCHK;
               result.frame_address  = address_ff;
               result.control_value  = control_ff;
               result.frame_number   = number_ff;
               result.payload_length = length_ff;
               result.is_last        = 1'b1;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
   end

   // Advance the frame state once per processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         address_ff <= '0;
         control_ff <= '0;
         number_ff  <= '0;
         length_ff  <= '0;
         left_ff    <= '0;
         xor_ff     <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         address_ff <= address_in;
         control_ff <= control_in;
         number_ff  <= number_in;
         length_ff  <= length_in;
         left_ff    <= left_in;
         xor_ff     <= xor_in;
      end
   end

endmodule

[design/sfr_rsp_stage.sv]
// Result register: holds one result until the consumer takes it.
// Depends on sfr_pkg for the result struct.
module sfr_rsp_stage
   import sfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  logic    has_result,
   input  rsp_type result,
   output logic    out_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Slot is free when empty or when its result leaves this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = has_result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new result only when one is produced
   always_ff @(posedge clock) begin
      if (load && has_result) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[design/serial_frame_receiver_xor_check_core.sv]
// Serial frame receiver with XOR block check: top level.
// An accepted byte waits in the input register until the result slot is free; its result
// is then captured in the result register.
// Throughput: one byte per cycle without back-pressure; both registers refill as they drain.
// Reset (synchronous): phase to waiting for sync, held fields and XOR to zero,
// sync value to 22 and data code to 2, both stages empty.
module serial_frame_receiver_xor_check_core
   import sfr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [ByteWidth-1:0]     req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_event_kind,
   output logic [ByteWidth-1:0]     rsp_payload_value,
   output logic [ByteWidth-1:0]     rsp_frame_address,
   output logic [ByteWidth-1:0]     rsp_control_value,
   output logic [2:0]               rsp_control_class,
   output logic [ByteWidth-1:0]     rsp_frame_number,
   output logic [ByteWidth-1:0]     rsp_payload_length,
   output logic                     rsp_is_last,
   input  logic                     csr_write_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]     csr_wdata
);

   logic [ByteWidth-1:0] sync_value_ff;
   logic [ByteWidth-1:0] data_code_ff;
   logic                 in_valid;
   logic [ByteWidth-1:0] in_byte;
   logic                 out_free;
   logic                 advance;
   logic                 has_result;
   rsp_type              result;
   rsp_type              rsp_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_value_ff <= SYNC_VALUE_RESET;
         data_code_ff  <= DATA_CODE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SYNC_VALUE: sync_value_ff <= csr_wdata;
            CSR_DATA_CODE:  data_code_ff  <= csr_wdata;
            default:        sync_value_ff <= sync_value_ff;
         endcase
      end
   end

   // Process the held byte whenever the result slot can take its outcome
   assign advance = in_valid && out_free;

   sfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .in_valid    (in_valid),
      .in_byte     (in_byte)
   );

   sfr_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_byte    (in_byte),
      .sync_value (sync_value_ff),
      .data_code  (data_code_ff),
      .has_result (has_result),
      .result     (result)
   );

   sfr_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .has_result (has_result),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   assign rsp_event_kind     = rsp_data.event_kind;
   assign rsp_payload_value  = rsp_data.payload_value;
   assign rsp_frame_address  = rsp_data.frame_address;
   assign rsp_control_value  = rsp_data.control_value;
   assign rsp_control_class  = rsp_data.control_class;
   assign rsp_frame_number   = rsp_data.frame_number;
   assign rsp_payload_length = rsp_data.payload_length;
   assign rsp_is_last        = rsp_data.is_last;

   // Only frame-closing events carry the last flag
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_last) |->
         (rsp_data.event_kind == EV_OK || rsp_data.event_kind == EV_BADCHK ||
          rsp_data.event_kind == EV_CTRL))
      else $error("last flag on a non-closing event");

   // Payload value is zero outside payload events
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_kind != EV_PAYLOAD) |-> (rsp_payload_value == BYTE_ZERO))
      else $error("payload value on a non-payload event");

   // A held byte that cannot advance stays put
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !advance) |=> (in_valid && $stable(in_byte)))
      else $error("input byte lost while stalled");

   // A stalled result slot blocks processing
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !advance)
      else $error("byte processed while result slot full");

endmodule
